// ===== src/llist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package llist_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W       = 10;
	localparam int VAL_W       = 32;
	localparam int CMD_W       = 4;
	localparam int ST_W        = 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  count_t;

	localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 4'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_GET       = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SET       = 4'd7;
	localparam logic [CMD_W-1:0] CMD_REVERSE   = 4'd8;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== src/llist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/indexed_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded singly linked list of signed 32-bit values held in two slot memories.
// Request channel: drive cmd, position and item_value and raise start; the request
// is taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown.
// Result channel: done pulses for one cycle with read_value, status and
// list_length; the receiver cannot stall it, so it must take the result then.
// Commands that walk the list from the head follow k links: get and set with
// k = index, delete last with k = length - 2, insert and delete in the middle
// with k = index - 1; reverse walks the whole list. Append, prepend and delete
// first walk no links. A new request can be taken in the cycle after the
// result. The single read port of the link memory paces every walk.
// Reset: the link memory is chained into a free list by a pass over all 256
// slots after reset, one slot per cycle; busy is high during that pass.
// Requests that fail (full list, index out of range, unknown command) change
// nothing and return their result in the next cycle.

module indexed_linked_list_engine_core
	import llist_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [CMD_W-1:0]        cmd,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] item_value,
	output logic                         done,
	output logic signed [VAL_W-1:0]      read_value,
	output logic [ST_W-1:0]              status,
	output logic [CNT_W-1:0]             list_length
);

	localparam logic [4:0] S_INIT      = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_WALK      = 5'd2;
	localparam logic [4:0] S_WSTEP     = 5'd3;
	localparam logic [4:0] S_TAKE_RD   = 5'd4;
	localparam logic [4:0] S_TAKE_WR   = 5'd5;
	localparam logic [4:0] S_TAKE_FIN  = 5'd6;
	localparam logic [4:0] S_INS_RD    = 5'd7;
	localparam logic [4:0] S_INS_WT    = 5'd8;
	localparam logic [4:0] S_FRONT_RD  = 5'd9;
	localparam logic [4:0] S_FRONT_WT  = 5'd10;
	localparam logic [4:0] S_BACK_FIX  = 5'd11;
	localparam logic [4:0] S_MID_RD    = 5'd12;
	localparam logic [4:0] S_MID_WT    = 5'd13;
	localparam logic [4:0] S_MID_RD2   = 5'd14;
	localparam logic [4:0] S_MID_FIX   = 5'd15;
	localparam logic [4:0] S_GIVE      = 5'd16;
	localparam logic [4:0] S_GET_RD    = 5'd17;
	localparam logic [4:0] S_GET_WT    = 5'd18;
	localparam logic [4:0] S_SET_WR    = 5'd19;
	localparam logic [4:0] S_REV       = 5'd20;
	localparam logic [4:0] S_REV_WR    = 5'd21;
	localparam logic [4:0] S_RESP      = 5'd22;

	// how a freshly taken slot is linked in
	localparam logic [1:0] K_APP = 2'd0;
	localparam logic [1:0] K_PRE = 2'd1;
	localparam logic [1:0] K_MID = 2'd2;

	logic [4:0] state_q;
	logic [4:0] ret_q;
	logic [1:0] kind_q;
	slot_t      init_q;
	slot_t      head_q, tail_q, free_q;
	count_t     count_q;
	count_t     wcnt_q;
	slot_t      cur_q, prev_q, vic_q, new_q, lnk_q;
	logic [VAL_W-1:0]        val_q;
	logic [VAL_W-1:0]        rv_q;
	logic [ST_W-1:0]         st_q;

	// link memory port
	logic  l_we;
	slot_t l_waddr, l_wdata, l_raddr, l_rdata;
	// value memory port
	logic             v_we;
	slot_t            v_waddr, v_raddr;
	logic [VAL_W-1:0] v_wdata, v_rdata;

	logic             full;
	logic [POS_W-1:0] count_ext;
	logic             pos_ge_count;
	logic             pos_ge_last;

	assign full         = (count_q >= count_t'(MAX_ENTRIES));
	assign count_ext    = POS_W'(count_q);
	assign pos_ge_count = (position >= count_ext);
	assign pos_ge_last  = (position >= (count_ext - POS_W'(1)));

	llist_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_links (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	llist_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_values (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// Memory port steering: each state issues at most one link write and one read.
	always_comb begin
		l_we    = 1'b0;
		l_waddr = cur_q;
		l_wdata = '0;
		l_raddr = cur_q;
		v_we    = 1'b0;
		v_waddr = free_q;
		v_wdata = val_q;
		v_raddr = cur_q;
		unique case (state_q)
			S_INIT: begin
				l_we    = 1'b1;
				l_waddr = init_q;
				l_wdata = init_q + slot_t'(1);
			end
			S_TAKE_RD:  l_raddr = free_q;
			S_TAKE_WR: begin
				l_we    = 1'b1;
				l_waddr = free_q;
				l_wdata = lnk_q;
				v_we    = 1'b1;
			end
			S_TAKE_FIN: begin
				// append links the old tail, insert links the predecessor
				l_wdata = new_q;
				if (kind_q == K_APP) begin
					l_we    = (count_q != '0);
					l_waddr = tail_q;
				end else if (kind_q == K_MID) begin
					l_we    = 1'b1;
					l_waddr = cur_q;
				end
			end
			S_FRONT_RD: l_raddr = head_q;
			S_BACK_FIX: l_we = 1'b1;
			S_MID_RD2:  l_raddr = vic_q;
			S_MID_FIX: begin
				l_we    = 1'b1;
				l_wdata = l_rdata;
			end
			S_GIVE: begin
				l_we    = 1'b1;
				l_waddr = vic_q;
				l_wdata = free_q;
			end
			S_SET_WR: begin
				v_we    = 1'b1;
				v_waddr = cur_q;
			end
			S_REV_WR: begin
				l_we    = 1'b1;
				l_wdata = prev_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + slot_t'(1);
					if (init_q == slot_t'(MAX_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_RESP;
					end
					if (start) begin
						priority case (cmd)
							CMD_APPEND: begin
								if (!full) state_q <= S_TAKE_RD;
							end
							CMD_PREPEND: begin
								if (!full) state_q <= S_TAKE_RD;
							end
							CMD_INSERT: begin
								if (full || count_q == '0 || position == '0 || pos_ge_count) begin
									if (!full) state_q <= S_TAKE_RD;
								end else begin
									state_q <= S_WALK;
								end
							end
							CMD_DEL_LAST: begin
								if (count_q > count_t'(1)) state_q <= S_WALK;
								else if (count_q != '0) state_q <= S_GIVE;
							end
							CMD_DEL_FIRST: begin
								if (count_q != '0) state_q <= S_FRONT_RD;
							end
							CMD_DEL_AT: begin
								if (count_q == '0) begin
									state_q <= S_RESP;
								end else if (pos_ge_last) begin
									state_q <= (count_q > count_t'(1)) ? S_WALK : S_GIVE;
								end else if (position == '0) begin
									state_q <= S_FRONT_RD;
								end else begin
									state_q <= S_WALK;
								end
							end
							CMD_GET, CMD_SET: begin
								if (!pos_ge_count) state_q <= S_WALK;
							end
							CMD_REVERSE: begin
								if (count_q > count_t'(1)) state_q <= S_REV;
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (wcnt_q == '0) state_q <= ret_q;
					else state_q <= S_WSTEP;
				end
				S_WSTEP:    state_q <= S_WALK;
				S_TAKE_RD:  state_q <= S_TAKE_WR;
				S_TAKE_WR: begin
					free_q  <= l_rdata;
					state_q <= S_TAKE_FIN;
				end
				S_TAKE_FIN: begin
					if (kind_q == K_APP) begin
						if (count_q == '0) head_q <= new_q;
						tail_q <= new_q;
					end else if (kind_q == K_PRE) begin
						if (count_q == '0) tail_q <= new_q;
						head_q <= new_q;
					end
					count_q <= count_q + count_t'(1);
					state_q <= S_RESP;
				end
				S_INS_RD:   state_q <= S_INS_WT;
				S_INS_WT:   state_q <= S_TAKE_RD;
				S_FRONT_RD: state_q <= S_FRONT_WT;
				S_FRONT_WT: begin
					head_q  <= l_rdata;
					state_q <= S_GIVE;
				end
				S_BACK_FIX: begin
					tail_q  <= cur_q;
					state_q <= S_GIVE;
				end
				S_MID_RD:   state_q <= S_MID_WT;
				S_MID_WT:   state_q <= S_MID_RD2;
				S_MID_RD2:  state_q <= S_MID_FIX;
				S_MID_FIX:  state_q <= S_GIVE;
				S_GIVE: begin
					// return the victim to the free list; an emptied list parks at zero
					free_q  <= vic_q;
					count_q <= count_q - count_t'(1);
					if (count_q == count_t'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end
					state_q <= S_RESP;
				end
				S_GET_RD:   state_q <= S_GET_WT;
				S_GET_WT:   state_q <= S_RESP;
				S_SET_WR:   state_q <= S_RESP;
				S_REV: begin
					if (wcnt_q == '0) begin
						head_q  <= tail_q;
						tail_q  <= head_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_REV_WR;
					end
				end
				S_REV_WR:   state_q <= S_REV;
				S_RESP:     state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the current request.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				val_q  <= item_value;
				rv_q   <= '0;
				st_q   <= ST_OK;
				cur_q  <= head_q;
				prev_q <= '0;
				lnk_q  <= '0;
				vic_q  <= tail_q;
				kind_q <= K_APP;
				wcnt_q <= '0;
				ret_q  <= S_RESP;
				if (start) begin
					priority case (cmd)
						CMD_APPEND: begin
							if (full) st_q <= ST_FULL;
						end
						CMD_PREPEND: begin
							if (full) st_q <= ST_FULL;
							kind_q <= K_PRE;
							lnk_q  <= (count_q == '0) ? '0 : head_q;
						end
						CMD_INSERT: begin
							if (full) begin
								st_q <= ST_FULL;
							end else if (count_q == '0 || position == '0) begin
								kind_q <= K_PRE;
								lnk_q  <= (count_q == '0) ? '0 : head_q;
							end else if (!pos_ge_count) begin
								kind_q <= K_MID;
								wcnt_q <= count_t'(position - POS_W'(1));
								ret_q  <= S_INS_RD;
							end
						end
						CMD_DEL_LAST: begin
							if (count_q == '0) st_q <= ST_RANGE;
							wcnt_q <= count_q - count_t'(2);
							ret_q  <= S_BACK_FIX;
						end
						CMD_DEL_FIRST: begin
							if (count_q == '0) st_q <= ST_RANGE;
						end
						CMD_DEL_AT: begin
							if (count_q == '0) begin
								st_q <= ST_RANGE;
							end else if (pos_ge_last) begin
								wcnt_q <= count_q - count_t'(2);
								ret_q  <= S_BACK_FIX;
							end else begin
								wcnt_q <= count_t'(position - POS_W'(1));
								ret_q  <= S_MID_RD;
							end
						end
						CMD_GET: begin
							if (pos_ge_count) st_q <= ST_RANGE;
							wcnt_q <= count_t'(position);
							ret_q  <= S_GET_RD;
						end
						CMD_SET: begin
							if (pos_ge_count) st_q <= ST_RANGE;
							wcnt_q <= count_t'(position);
							ret_q  <= S_SET_WR;
						end
						CMD_REVERSE: wcnt_q <= count_q;
						default:     st_q   <= ST_RANGE;
					endcase
				end
			end
			S_WSTEP: begin
				// advance one link along the list
				cur_q  <= l_rdata;
				wcnt_q <= wcnt_q - count_t'(1);
			end
			S_TAKE_WR:  new_q <= free_q;
			S_INS_WT:   lnk_q <= l_rdata;
			S_FRONT_WT: vic_q <= head_q;
			S_MID_WT:   vic_q <= l_rdata;
			S_GET_WT:   rv_q  <= v_rdata;
			S_REV_WR: begin
				prev_q <= cur_q;
				cur_q  <= l_rdata;
				wcnt_q <= wcnt_q - count_t'(1);
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign read_value  = rv_q;
	assign status      = st_q;
	assign list_length = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	a_empty_park: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty list with nonzero head or tail");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (list_length == count_t'(MAX_ENTRIES)))
		else $error("full status on a list with room");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0))
		else $error("failed request returned a value");

endmodule

`default_nettype wire
